[rtl/gld_pkg.sv]
// shared status, command, config codes and limits for the gif lzw raster decoder
package gld_pkg;

    typedef logic [2:0] status_t;
    typedef logic [1:0] cmd_t;

    localparam status_t ST_ACCEPT  = 3'd0;
    localparam status_t ST_PIXEL   = 3'd1;
    localparam status_t ST_NONE    = 3'd2;
    localparam status_t ST_END     = 3'd3;
    localparam status_t ST_ILLEGAL = 3'd4;
    localparam status_t ST_REFUSED = 3'd5;

    localparam cmd_t CMD_START = 2'd0;
    localparam cmd_t CMD_BYTE  = 2'd1;
    localparam cmd_t CMD_PULL  = 2'd2;

    localparam logic CFG_MIN_BITS = 1'b0;
    localparam logic CFG_EXPECTED = 1'b1;

    localparam logic [3:0] MIN_BITS_RESET = 4'd8;
    localparam logic [3:0] MIN_BITS_LOW   = 4'd2;
    localparam logic [3:0] MIN_BITS_HIGH  = 4'd8;

endpackage

[rtl/gld_ram.sv]
// generic single-write, single-read ram with registered read data
module gld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/gif_lzw_raster_decoder.sv]
// gif lzw raster decoder top level: byte unpacking, code sequencer, table and stack
//
// channel  dir  handshake          payload
// s_axis   in   s_tvalid/s_tready  s_tuser cmd, s_tdata data_byte
// m_axis   out  m_tvalid/m_tready  m_tuser status, m_tdata pixel and size_ok
// cfg      in   cfg_we             cfg_index, cfg_data
//
// start, refused, end and length-byte requests go from S_IDLE straight to S_RESP; a data byte with no code
// passes S_DEC first, and a pull passes S_DEC and S_PULL, adding S_POPW when a pixel is popped
// a decoded code passes S_CODE, S_F1, S_F2 and S_ENTRY, plus S_WALK and S_WALK2 per table step of its chain
// walk (a clear code only S_CODE); each walk step waits on the registered prefix and suffix table reads
// rst_n clears control state; tables and stack are not reset, and no entry's read data is used before it is written
// one request at a time; a waiting result stalls only the next finished result
module gif_lzw_raster_decoder
    import gld_pkg::*;
#(
    parameter int MAX_CODE_BITS = 12,
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // pixel[7:0], size_ok[8], zero[15:9]
    output logic [2:0]  m_tuser,   // status[2:0]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int NF_W   = ADDR_W + 1;
    localparam int CMP_W  = (MAX_CODE_BITS + 1 > NF_W) ? MAX_CODE_BITS + 1 : NF_W;
    localparam int ACC_W  = MAX_CODE_BITS + 8;
    localparam int HELD_W = $clog2(ACC_W + 1);
    localparam int CW_W   = $clog2(MAX_CODE_BITS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_CODE, S_F1, S_F2, S_ENTRY, S_WALK, S_WALK2,
        S_PULL, S_POPW, S_RESP
    } state_t;

    state_t              state_reg;
    logic [3:0]          min_bits_reg;
    logic [31:0]         expected_reg;
    logic [3:0]          amin_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [HELD_W-1:0]   held_reg;
    logic [CW_W-1:0]     cw_reg;
    logic [NF_W-1:0]     nf_reg;
    logic [ADDR_W-1:0]   prev_reg;
    logic                prev_valid_reg;
    logic [7:0]          bleft_reg;
    logic                fin_reg;
    logic [31:0]         pcount_reg;
    logic [NF_W-1:0]     sp_reg;
    cmd_t                cmd_reg;
    logic [CMP_W-1:0]    code_reg;
    logic                kw_reg;
    logic [7:0]          fc_reg;
    logic [7:0]          fp_reg;
    logic [ADDR_W-1:0]   c_reg;
    status_t             status_reg;
    logic [7:0]          pixel_reg;
    status_t             out_status_reg;
    logic [7:0]          out_pixel_reg;
    logic                out_size_ok_reg;

    logic [CMP_W-1:0]    clr;
    logic [CMP_W-1:0]    nf_ext;
    logic [CMP_W-1:0]    prev_ext;
    logic [CMP_W-1:0]    c_ext;
    logic [ACC_W-1:0]    mask;
    logic [ACC_W-1:0]    code_bits;
    logic [3:0]          clamp_min;
    logic [NF_W-1:0]     nf_inc;
    logic                table_room;

    logic                first_re, pre_re, stk_re, stk_we, tab_we;
    logic [ADDR_W-1:0]   first_raddr, stk_raddr, stk_waddr;
    logic [7:0]          stk_wdata, suf_wdata;
    logic [7:0]          first_rdata, suf_rdata, stk_rdata;
    logic [ADDR_W-1:0]   pre_rdata;

    assign clr        = CMP_W'(1) << amin_reg;
    assign nf_ext     = CMP_W'(nf_reg);
    assign prev_ext   = CMP_W'(prev_reg);
    assign c_ext      = CMP_W'(c_reg);
    assign mask       = (ACC_W'(1) << cw_reg) - ACC_W'(1);
    assign code_bits  = acc_reg & mask;
    assign nf_inc     = nf_reg + NF_W'(1);
    assign table_room = nf_reg < NF_W'(TABLE_ENTRIES);
    assign clamp_min  = (min_bits_reg < MIN_BITS_LOW) ? MIN_BITS_LOW :
                        (min_bits_reg > MIN_BITS_HIGH) ? MIN_BITS_HIGH : min_bits_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, out_size_ok_reg, out_pixel_reg};

    always_comb
    begin
        first_re    = (state_reg == S_CODE) || (state_reg == S_F1);
        first_raddr = (state_reg == S_CODE) ? code_reg[ADDR_W-1:0] : prev_reg;
        pre_re      = (state_reg == S_WALK) && (c_ext >= clr);
        tab_we      = (state_reg == S_ENTRY) && prev_valid_reg && table_room;
        suf_wdata   = kw_reg ? fp_reg : fc_reg;
        stk_re      = (state_reg == S_PULL) && (sp_reg != '0);
        stk_raddr   = ADDR_W'(sp_reg - NF_W'(1));
        stk_waddr   = sp_reg[ADDR_W-1:0];
        stk_we      = ((state_reg == S_WALK) && !(c_ext >= clr)) || (state_reg == S_WALK2);
        stk_wdata   = (state_reg == S_WALK2) ? suf_rdata : c_reg[7:0];
    end

    gld_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_ENTRIES)) u_prefix (
        .clk(clk), .we(tab_we), .waddr(nf_reg[ADDR_W-1:0]), .wdata(prev_reg),
        .re(pre_re), .raddr(c_reg), .rdata(pre_rdata)
    );

    gld_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_suffix (
        .clk(clk), .we(tab_we), .waddr(nf_reg[ADDR_W-1:0]), .wdata(suf_wdata),
        .re(pre_re), .raddr(c_reg), .rdata(suf_rdata)
    );

    gld_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_first (
        .clk(clk), .we(tab_we), .waddr(nf_reg[ADDR_W-1:0]), .wdata(fp_reg),
        .re(first_re), .raddr(first_raddr), .rdata(first_rdata)
    );

    gld_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            min_bits_reg    <= MIN_BITS_RESET;
            expected_reg    <= '0;
            amin_reg        <= MIN_BITS_RESET;
            acc_reg         <= '0;
            held_reg        <= '0;
            cw_reg          <= CW_W'(MIN_BITS_RESET) + CW_W'(1);
            nf_reg          <= (NF_W'(1) << MIN_BITS_RESET) + NF_W'(2);
            prev_reg        <= '0;
            prev_valid_reg  <= 1'b0;
            bleft_reg       <= '0;
            fin_reg         <= 1'b0;
            pcount_reg      <= '0;
            sp_reg          <= '0;
            cmd_reg         <= CMD_START;
            status_reg      <= ST_ACCEPT;
            out_status_reg  <= ST_ACCEPT;
            out_pixel_reg   <= '0;
            out_size_ok_reg <= 1'b0;
            m_tvalid        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MIN_BITS)
                begin
                    min_bits_reg <= cfg_data[3:0];
                end
                else
                begin
                    expected_reg <= cfg_data;
                end
            end
            if (m_tvalid && m_tready && state_reg != S_RESP)
            begin
                m_tvalid <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg <= s_tuser;
                        unique case (s_tuser)
                            CMD_START:
                            begin
                                amin_reg       <= clamp_min;
                                acc_reg        <= '0;
                                held_reg       <= '0;
                                cw_reg         <= CW_W'(clamp_min) + CW_W'(1);
                                nf_reg         <= (NF_W'(1) << clamp_min) + NF_W'(2);
                                prev_valid_reg <= 1'b0;
                                bleft_reg      <= '0;
                                fin_reg        <= 1'b0;
                                pcount_reg     <= '0;
                                sp_reg         <= '0;
                                status_reg     <= ST_ACCEPT;
                                state_reg      <= S_RESP;
                            end
                            CMD_BYTE:
                            begin
                                if (fin_reg)
                                begin
                                    status_reg <= ST_END;
                                    state_reg  <= S_RESP;
                                end
                                else if (sp_reg != '0 || held_reg >= HELD_W'(cw_reg))
                                begin
                                    status_reg <= ST_REFUSED;
                                    state_reg  <= S_RESP;
                                end
                                else if (bleft_reg == '0)
                                begin
                                    if (s_tdata == 8'd0)
                                    begin
                                        fin_reg    <= 1'b1;
                                        status_reg <= ST_END;
                                    end
                                    else
                                    begin
                                        bleft_reg  <= s_tdata;
                                        status_reg <= ST_ACCEPT;
                                    end
                                    state_reg <= S_RESP;
                                end
                                else
                                begin
                                    bleft_reg <= bleft_reg - 8'd1;
                                    acc_reg   <= acc_reg | (ACC_W'(s_tdata) << held_reg);
                                    held_reg  <= held_reg + HELD_W'(8);
                                    state_reg <= S_DEC;
                                end
                            end
                            CMD_PULL:
                            begin
                                state_reg <= S_DEC;
                            end
                            default:
                            begin
                                status_reg <= ST_REFUSED;
                                state_reg  <= S_RESP;
                            end
                        endcase
                    end
                end
                S_DEC:
                begin
                    if (fin_reg || sp_reg != '0 || held_reg < HELD_W'(cw_reg))
                    begin
                        status_reg <= ST_ACCEPT;
                        state_reg  <= (cmd_reg == CMD_PULL) ? S_PULL : S_RESP;
                    end
                    else
                    begin
                        code_reg  <= code_bits[CMP_W-1:0];
                        acc_reg   <= acc_reg >> cw_reg;
                        held_reg  <= held_reg - HELD_W'(cw_reg);
                        state_reg <= S_CODE;
                    end
                end
                S_CODE:
                begin
                    kw_reg <= (code_reg == nf_ext);
                    if (code_reg == clr)
                    begin
                        cw_reg         <= CW_W'(amin_reg) + CW_W'(1);
                        nf_reg         <= NF_W'(clr) + NF_W'(2);
                        prev_valid_reg <= 1'b0;
                        state_reg      <= S_DEC;
                    end
                    else if (code_reg == clr + CMP_W'(1))
                    begin
                        fin_reg    <= 1'b1;
                        status_reg <= ST_END;
                        state_reg  <= S_RESP;
                    end
                    else if (code_reg < nf_ext ||
                             (code_reg == nf_ext && prev_valid_reg && table_room))
                    begin
                        state_reg <= S_F1;
                    end
                    else
                    begin
                        fin_reg    <= 1'b1;
                        status_reg <= ST_ILLEGAL;
                        state_reg  <= S_RESP;
                    end
                end
                S_F1:
                begin
                    fc_reg    <= (code_reg < clr) ? code_reg[7:0] : first_rdata;
                    state_reg <= S_F2;
                end
                S_F2:
                begin
                    fp_reg    <= (prev_ext < clr) ? prev_reg[7:0] : first_rdata;
                    c_reg     <= code_reg[ADDR_W-1:0];
                    state_reg <= kw_reg ? S_ENTRY : S_WALK;
                end
                S_ENTRY:
                begin
                    if (prev_valid_reg && table_room)
                    begin
                        nf_reg <= nf_inc;
                        if (cw_reg < CW_W'(MAX_CODE_BITS) &&
                            CMP_W'(nf_inc) == (CMP_W'(1) << cw_reg))
                        begin
                            cw_reg <= cw_reg + CW_W'(1);
                        end
                    end
                    if (kw_reg)
                    begin
                        state_reg <= S_WALK;
                    end
                    else
                    begin
                        prev_reg       <= code_reg[ADDR_W-1:0];
                        prev_valid_reg <= 1'b1;
                        state_reg      <= S_DEC;
                    end
                end
                S_WALK:
                begin
                    if (c_ext >= clr)
                    begin
                        state_reg <= S_WALK2;
                    end
                    else
                    begin
                        sp_reg <= sp_reg + NF_W'(1);
                        if (kw_reg)
                        begin
                            prev_reg       <= code_reg[ADDR_W-1:0];
                            prev_valid_reg <= 1'b1;
                            state_reg      <= S_DEC;
                        end
                        else
                        begin
                            state_reg <= S_ENTRY;
                        end
                    end
                end
                S_WALK2:
                begin
                    sp_reg    <= sp_reg + NF_W'(1);
                    c_reg     <= pre_rdata;
                    state_reg <= S_WALK;
                end
                S_PULL:
                begin
                    if (sp_reg != '0)
                    begin
                        sp_reg <= sp_reg - NF_W'(1);
                        if (pcount_reg != '1)
                        begin
                            pcount_reg <= pcount_reg + 32'd1;
                        end
                        state_reg <= S_POPW;
                    end
                    else
                    begin
                        status_reg <= fin_reg ? ST_END : ST_NONE;
                        state_reg  <= S_RESP;
                    end
                end
                S_POPW:
                begin
                    pixel_reg  <= stk_rdata;
                    status_reg <= ST_PIXEL;
                    state_reg  <= S_RESP;
                end
                S_RESP:
                begin
                    if (!m_tvalid || m_tready)
                    begin
                        m_tvalid        <= 1'b1;
                        out_status_reg  <= status_reg;
                        out_pixel_reg   <= (status_reg == ST_PIXEL) ? pixel_reg : 8'd0;
                        out_size_ok_reg <= (status_reg == ST_END) &&
                                           (pcount_reg == expected_reg);
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[sim/tb_gif_lzw_raster_decoder.sv]
// self-checking testbench for the gif lzw raster decoder
module tb_gif_lzw_raster_decoder;
    import gld_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t    status;
        logic [7:0] pixel;
        logic       size_ok;
    } answer_t;

    typedef struct {
        cmd_t       cmd;
        logic [7:0] data;
        logic       known;
        answer_t    ans;
    } row_t;

    localparam int TBL = 4096;
    localparam logic [12:0] NO_PREV = 13'h1FFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    gif_lzw_raster_decoder uut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic [3:0]  cur_min_bits;
    logic [31:0] cur_expected;
    logic [3:0]  img_min;
    logic [11:0] pre_tbl [TBL];
    logic [7:0]  suf_tbl [TBL];
    logic [7:0]  head_tbl [TBL];
    logic [7:0]  pix_stack [TBL];
    int unsigned depth;
    logic [19:0] acc;
    int unsigned held;
    int unsigned width;
    int unsigned free_code;
    logic [12:0] prev;
    int unsigned blk_left;
    logic        done_img;
    logic [31:0] pix_count;

    answer_t pending_answers[$];
    int errors = 0;
    bit stim_done = 0;

    function automatic int unsigned clear_of();
        return 1 << img_min;
    endfunction

    function automatic logic [7:0] head_of(int unsigned c);
        if (c < clear_of() || c >= TBL)
            return c[7:0];
        return head_tbl[c];
    endfunction

    task automatic add_code(int unsigned p, logic [7:0] s);
        if (free_code >= TBL)
            return;
        pre_tbl[free_code] = p[11:0];
        head_tbl[free_code] = head_of(p);
        suf_tbl[free_code] = s;
        free_code++;
        if (width < 12 && free_code == (1 << width))
            width++;
    endtask

    task automatic push_chain(int unsigned code);
        int unsigned c;
        c = code;
        while (c >= clear_of() && c < TBL && depth < TBL)
        begin
            pix_stack[depth] = suf_tbl[c];
            depth++;
            c = pre_tbl[c];
        end
        if (depth < TBL)
        begin
            pix_stack[depth] = c[7:0];
            depth++;
        end
    endtask

    // 0 ok, 1 end of information, 2 illegal
    task automatic apply_code(int unsigned code, output int r);
        int unsigned clr;
        int unsigned idx;
        clr = clear_of();
        r = 0;
        if (code == clr)
        begin
            width = img_min + 1;
            free_code = clr + 2;
            prev = NO_PREV;
        end
        else if (code == clr + 1)
            r = 1;
        else if (code < free_code)
        begin
            push_chain(code);
            if (prev != NO_PREV)
                add_code(prev, head_of(code));
            prev = code;
        end
        else if (code == free_code && prev != NO_PREV && free_code < TBL)
        begin
            idx = free_code;
            add_code(prev, head_of(prev));
            push_chain(idx);
            prev = code;
        end
        else
            r = 2;
    endtask

    task automatic drain_codes(output status_t st);
        int unsigned code;
        int r;
        st = ST_ACCEPT;
        while (!done_img && depth == 0 && held >= width)
        begin
            code = acc & ((1 << width) - 1);
            acc = acc >> width;
            held -= width;
            apply_code(code, r);
            if (r != 0)
            begin
                done_img = 1'b1;
                st = (r == 1) ? ST_END : ST_ILLEGAL;
                return;
            end
        end
    endtask

    task automatic begin_image();
        img_min = cur_min_bits < 2 ? 4'd2 : (cur_min_bits > 8 ? 4'd8 : cur_min_bits);
        depth = 0;
        acc = '0;
        held = 0;
        width = img_min + 1;
        free_code = clear_of() + 2;
        prev = NO_PREV;
        blk_left = 0;
        done_img = 1'b0;
        pix_count = '0;
    endtask

    task automatic predict_request(cmd_t cmd, logic [7:0] b, output answer_t a);
        status_t st;
        logic [7:0] px;
        st = ST_ACCEPT;
        px = '0;
        if (cmd == CMD_START)
            begin_image();
        else if (cmd == CMD_BYTE)
        begin
            if (done_img)
                st = ST_END;
            else if (depth > 0 || held >= width)
                st = ST_REFUSED;
            else if (blk_left == 0)
            begin
                if (b == 0)
                begin
                    done_img = 1'b1;
                    st = ST_END;
                end
                else
                    blk_left = b;
            end
            else
            begin
                blk_left--;
                acc = (acc | (20'(b) << held));
                held += 8;
                drain_codes(st);
            end
        end
        else if (cmd == CMD_PULL)
        begin
            if (depth == 0 && !done_img)
                drain_codes(st);
            if (st == ST_ACCEPT)
            begin
                if (depth > 0)
                begin
                    depth--;
                    px = pix_stack[depth];
                    if (pix_count != 32'hFFFFFFFF)
                        pix_count++;
                    st = ST_PIXEL;
                end
                else if (done_img)
                    st = ST_END;
                else
                    st = ST_NONE;
            end
        end
        else
            st = ST_REFUSED;
        a.status = st;
        a.pixel = (st == ST_PIXEL) ? px : 8'd0;
        a.size_ok = (st == ST_END && pix_count == cur_expected);
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result side
    initial
    begin
        answer_t w;
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, 14);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            if (pending_answers.size() == 0)
            begin
                report("unexpected result status", m_tuser, -1);
            end
            else
            begin
                w = pending_answers.pop_front();
                if (m_tuser != w.status)
                    report("status", m_tuser, w.status);
                if (m_tdata[7:0] != w.pixel)
                    report("pixel", m_tdata[7:0], w.pixel);
                if (m_tdata[8] != w.size_ok)
                    report("size_ok", m_tdata[8], w.size_ok);
                if (m_tdata[15:9] != 0)
                    report("pad bits", m_tdata[15:9], 0);
            end
        end
    end

    int sender_gap_max = 14;

    task automatic send(cmd_t cmd, logic [7:0] b, logic known, answer_t given);
        answer_t a;
        int gap;
        gap = $urandom_range(0, sender_gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tuser <= cmd;
        s_tdata <= b;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_request(cmd, b, a);
        if (known && a != given)
            report("table row", given, a);
        pending_answers.push_back(known ? given : a);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_MIN_BITS)
            cur_min_bits = v[3:0];
        else
            cur_expected = v;
    endtask

    // one image: clear, random codes mostly legal, then eoi, packed into sub-blocks
    task automatic run_image(int unsigned ncodes, bit noisy);
        logic [7:0] bytes[$];
        logic [31:0] bits;
        int nb;
        int unsigned w, nf, clr, code, k, m, blk;
        bit has_prev;
        clr = 1 << img_min;
        w = img_min + 1;
        nf = clr + 2;
        has_prev = 0;
        bits = '0;
        nb = 0;
        for (k = 0; k <= ncodes + 1; k++)
        begin
            if (k == 0)
                code = clr;
            else if (k == ncodes + 1)
                code = clr + 1;
            else if (noisy && $urandom_range(0, 30) == 0)
                code = $urandom_range(0, (1 << w) - 1);
            else if (has_prev && $urandom_range(0, 5) == 0)
                code = nf < TBL ? nf : 0;
            else if ($urandom_range(0, 1) == 0 || nf == clr + 2)
                code = $urandom_range(0, clr - 1);
            else
                code = $urandom_range(clr + 2, nf - 1);
            if (code == clr && k != 0)
                code = 0;
            bits = bits | (code << nb);
            nb += w;
            while (nb >= 8)
            begin
                bytes.push_back(bits[7:0]);
                bits = bits >> 8;
                nb -= 8;
            end
            if (code == clr)
            begin
                w = img_min + 1;
                nf = clr + 2;
                has_prev = 0;
            end
            else
            begin
                if (has_prev && nf < TBL)
                begin
                    nf++;
                    if (w < 12 && nf == (1 << w))
                        w++;
                end
                has_prev = 1;
            end
        end
        if (nb > 0)
            bytes.push_back(bits[7:0]);
        m = 0;
        while (m < bytes.size())
        begin
            blk = $urandom_range(1, 255);
            if (blk > bytes.size() - m)
                blk = bytes.size() - m;
            send(CMD_BYTE, blk[7:0], 0, '0);
            for (k = 0; k < blk; k++)
            begin
                send(CMD_BYTE, bytes[m], 0, '0);
                while (depth > 0 || (held >= width && !done_img))
                    send(CMD_PULL, 8'd0, 0, '0);
                m++;
            end
        end
        send(CMD_BYTE, 8'd0, 0, '0);
        send(CMD_PULL, 8'd0, 0, '0);
    endtask

    initial
    begin
        row_t dir[$];
        row_t r;
        int n;
        cur_min_bits = MIN_BITS_RESET;
        cur_expected = '0;
        for (int i = 0; i < TBL; i++)
        begin
            pre_tbl[i] = '0;
            suf_tbl[i] = '0;
            head_tbl[i] = '0;
            pix_stack[i] = '0;
        end
        begin_image();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: min 2; clear, pixel 3, clear, pixel 2; empty image; illegal code
        write_cfg(CFG_MIN_BITS, 32'd2);
        write_cfg(CFG_EXPECTED, 32'd3);
        dir = '{
            '{CMD_PULL, 8'h00, 1, '{ST_NONE, 8'd0, 1'b0}},
            '{2'd3, 8'hFF, 1, '{ST_REFUSED, 8'd0, 1'b0}},
            '{CMD_START, 8'hFF, 1, '{ST_ACCEPT, 8'd0, 1'b0}},
            '{CMD_BYTE, 8'd2, 1, '{ST_ACCEPT, 8'd0, 1'b0}},
            '{CMD_BYTE, 8'b0001_1100, 0, '0},
            '{CMD_BYTE, 8'h00, 1, '{ST_REFUSED, 8'd0, 1'b0}},
            '{CMD_PULL, 8'h00, 0, '0},
            '{CMD_PULL, 8'h00, 0, '0},
            '{CMD_PULL, 8'h00, 0, '0},
            '{CMD_BYTE, 8'b0000_0101, 0, '0},
            '{CMD_PULL, 8'h00, 0, '0},
            '{CMD_BYTE, 8'hAA, 0, '0},
            '{CMD_START, 8'h00, 1, '{ST_ACCEPT, 8'd0, 1'b0}},
            '{CMD_BYTE, 8'h00, 1, '{ST_END, 8'd0, 1'b0}},
            '{CMD_PULL, 8'h00, 1, '{ST_END, 8'd0, 1'b0}},
            '{CMD_START, 8'h00, 1, '{ST_ACCEPT, 8'd0, 1'b0}},
            '{CMD_BYTE, 8'd1, 1, '{ST_ACCEPT, 8'd0, 1'b0}},
            '{CMD_BYTE, 8'hFF, 1, '{ST_ILLEGAL, 8'd0, 1'b0}},
            '{CMD_BYTE, 8'h55, 1, '{ST_END, 8'd0, 1'b0}}
        };
        foreach (dir[i])
        begin
            r = dir[i];
            send(r.cmd, r.data, r.known, r.ans);
        end
        wait_idle();

        // random images across min code sizes, out-of-range values included
        n = 0;
        while (n < 60)
        begin
            write_cfg(CFG_MIN_BITS, (n % 10 == 0) ? 32'd0 : ((n % 10 == 1) ? 32'd15
                : $urandom_range(2, 8)));
            write_cfg(CFG_EXPECTED, (n % 7 == 0) ? 32'hFFFFFFFF : ((n % 7 == 1) ? 32'd0
                : $urandom_range(0, 40)));
            sender_gap_max = (n % 5 == 0) ? 0 : 14;
            send(CMD_START, 8'($urandom), 0, '0);
            run_image($urandom_range(1, 12), n % 3 == 0);
            if (n % 4 == 0)
                repeat ($urandom_range(1, 6))
                    send(cmd_t'($urandom_range(0, 3)), 8'($urandom), 0, '0);
            wait_idle();
            n++;
        end
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
